FILE: rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants of the bounding box proxy fitter
// Vertex extremes record, proxy kind codes and count limits.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // saturating vertex counter
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  // configuration register
  localparam int unsigned LimitW = 16;
  localparam logic [LimitW-1:0] LIMIT_RESET = 16'd500;

  // extremes at the start of a mesh
  localparam logic signed [31:0] COORD_POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_NEG_MAX = 32'sh8000_0000;

  // proxy kinds as they appear on proxy_kind
  typedef enum logic [1:0] {
    KIND_MESH = 2'd0,
    KIND_CAPS = 2'd1,
    KIND_BOX  = 2'd2
  } proxy_kind_t;

  // final extremes of one mesh, handed from accumulator to emitter
  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] hi_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] hi_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_z;
    logic               force_mesh;
  } aabb_box_t;

endpackage

FILE: rtl/aabb_accum.sv
// ----------------------------------------------------------------------------
// aabb_accum: running per-axis extremes and vertex count
// Folds one vertex per cycle into the extremes unless stalled; on the last
// vertex the final box is latched for the emitter and running state restarts.
// ----------------------------------------------------------------------------
module aabb_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vertex_valid,
  output logic                          vertex_stall,
  input  logic signed [31:0]            coord_x,
  input  logic signed [31:0]            coord_y,
  input  logic signed [31:0]            coord_z,
  input  logic                          mesh_static,
  input  logic                          last_vertex,
  input  logic [aabb_pkg::LimitW-1:0]   limit,
  input  logic                          busy,
  output logic                          snap_valid,
  output aabb_pkg::aabb_box_t           snap
);
  import aabb_pkg::*;

  logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [CountW-1:0]  count;

  logic signed [31:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next, lo_z_next, hi_z_next;
  logic [CountW-1:0]  count_next;
  logic               accept;
  logic               over_limit;

  // a last vertex waits until the previous mesh's results are out
  assign vertex_stall = busy && last_vertex;
  assign accept       = vertex_valid && !vertex_stall;

  // fold the vertex into the extremes
  always_comb begin
    lo_x_next  = (coord_x < lo_x) ? coord_x : lo_x;
    hi_x_next  = (coord_x > hi_x) ? coord_x : hi_x;
    lo_y_next  = (coord_y < lo_y) ? coord_y : lo_y;
    hi_y_next  = (coord_y > hi_y) ? coord_y : hi_y;
    lo_z_next  = (coord_z < lo_z) ? coord_z : lo_z;
    hi_z_next  = (coord_z > hi_z) ? coord_z : hi_z;
    count_next = (count == COUNT_MAX) ? count : count + 1'b1;
    over_limit = count_next > {{(CountW-LimitW){1'b0}}, limit};
  end

  // running state; restarts after a last vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_x  <= COORD_POS_MAX;
      hi_x  <= COORD_NEG_MAX;
      lo_y  <= COORD_POS_MAX;
      hi_y  <= COORD_NEG_MAX;
      lo_z  <= COORD_POS_MAX;
      hi_z  <= COORD_NEG_MAX;
      count <= '0;
    end else if (accept) begin
      if (last_vertex) begin
        lo_x  <= COORD_POS_MAX;
        hi_x  <= COORD_NEG_MAX;
        lo_y  <= COORD_POS_MAX;
        hi_y  <= COORD_NEG_MAX;
        lo_z  <= COORD_POS_MAX;
        hi_z  <= COORD_NEG_MAX;
        count <= '0;
      end else begin
        lo_x  <= lo_x_next;
        hi_x  <= hi_x_next;
        lo_y  <= lo_y_next;
        hi_y  <= hi_y_next;
        lo_z  <= lo_z_next;
        hi_z  <= hi_z_next;
        count <= count_next;
      end
    end
  end

  // final box of the mesh, one-cycle strobe to the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= accept && last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_vertex) begin
      snap.lo_x       <= lo_x_next;
      snap.hi_x       <= hi_x_next;
      snap.lo_y       <= lo_y_next;
      snap.hi_y       <= hi_y_next;
      snap.lo_z       <= lo_z_next;
      snap.hi_z       <= hi_z_next;
      snap.force_mesh <= mesh_static || over_limit;
    end
  end

endmodule

FILE: rtl/aabb_emit.sv
// ----------------------------------------------------------------------------
// aabb_emit: proxy decision and result sequencing
// Computes extents, picks mesh, capsule or box, then sends the results
// one per transfer through the output register.
// ----------------------------------------------------------------------------
module aabb_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  input  aabb_pkg::aabb_box_t   snap,
  output logic                  busy,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [1:0]            proxy_kind,
  output logic signed [31:0]    point_x,
  output logic signed [31:0]    point_y,
  output logic signed [31:0]    point_z,
  output logic [30:0]           radius,
  output logic                  last_result
);
  import aabb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXT  = 4'b0010,
    ST_DEC  = 4'b0100,
    ST_EMIT = 4'b1000
  } emit_state_t;

  emit_state_t state, state_next;

  // extents and centres
  logic [31:0]        ext_x, ext_y, ext_z;
  logic signed [31:0] cen_x, cen_z;
  // decision
  proxy_kind_t        kind;
  logic [30:0]        rad;
  logic signed [31:0] end_a_y, end_b_y;
  logic [2:0]         idx, last_idx;

  logic signed [32:0] sum_x, sum_z;
  logic [32:0]        dif_x, dif_y, dif_z;
  logic [31:0]        wmax;
  logic [33:0]        wmax3;
  logic               is_caps;
  proxy_kind_t        kind_next;
  logic               slot_free;
  logic               load;

  proxy_kind_t        o_kind;
  logic signed [31:0] o_x, o_y, o_z;
  logic [30:0]        o_rad;

  assign busy      = snap_valid || (state != ST_IDLE);
  assign slot_free = !result_valid || !result_stall;
  assign load      = (state == ST_EMIT) && slot_free;

  // extents and floored centres
  always_comb begin
    dif_x = {snap.hi_x[31], snap.hi_x} - {snap.lo_x[31], snap.lo_x};
    dif_y = {snap.hi_y[31], snap.hi_y} - {snap.lo_y[31], snap.lo_y};
    dif_z = {snap.hi_z[31], snap.hi_z} - {snap.lo_z[31], snap.lo_z};
    sum_x = {snap.lo_x[31], snap.lo_x} + {snap.hi_x[31], snap.hi_x};
    sum_z = {snap.lo_z[31], snap.lo_z} + {snap.hi_z[31], snap.hi_z};
  end

  // capsule test: height > 3 * wider extent, extent nonzero
  always_comb begin
    wmax    = (ext_x > ext_z) ? ext_x : ext_z;
    wmax3   = {1'b0, wmax, 1'b0} + {2'b00, wmax};
    is_caps = (wmax != '0) && ({2'b00, ext_y} > wmax3);
    if (snap.force_mesh) begin
      kind_next = KIND_MESH;
    end else if (is_caps) begin
      kind_next = KIND_CAPS;
    end else begin
      kind_next = KIND_BOX;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (snap_valid) state_next = ST_EXT;
      ST_EXT:  state_next = ST_DEC;
      ST_DEC:  state_next = ST_EMIT;
      ST_EMIT: if (load && (idx == last_idx)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXT) begin
      ext_x <= dif_x[31:0];
      ext_y <= dif_y[31:0];
      ext_z <= dif_z[31:0];
      cen_x <= sum_x[32:1];
      cen_z <= sum_z[32:1];
    end
    if (state == ST_DEC) begin
      kind    <= kind_next;
      rad     <= wmax[31:1];
      end_a_y <= snap.lo_y + $signed({1'b0, wmax[31:1]});
      end_b_y <= snap.hi_y - $signed({1'b0, wmax[31:1]});
      case (kind_next)
        KIND_MESH: last_idx <= 3'd0;
        KIND_CAPS: last_idx <= 3'd1;
        default:   last_idx <= 3'd7;
      endcase
    end
  end

  // result index within the mesh
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == ST_DEC) begin
      idx <= '0;
    end else if (load) begin
      idx <= idx + 1'b1;
    end
  end

  // payload of the current result
  always_comb begin
    o_kind = kind;
    o_x    = '0;
    o_y    = '0;
    o_z    = '0;
    o_rad  = '0;
    case (kind)
      KIND_CAPS: begin
        o_x   = cen_x;
        o_y   = idx[0] ? end_b_y : end_a_y;
        o_z   = cen_z;
        o_rad = rad;
      end
      KIND_BOX: begin
        o_x = idx[0] ? snap.hi_x : snap.lo_x;
        o_y = idx[1] ? snap.hi_y : snap.lo_y;
        o_z = idx[2] ? snap.hi_z : snap.lo_z;
      end
      default: begin
        o_kind = KIND_MESH;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      proxy_kind  <= o_kind;
      point_x     <= o_x;
      point_y     <= o_y;
      point_z     <= o_z;
      radius      <= o_rad;
      last_result <= (idx == last_idx);
    end
  end

  // a new box only arrives while the sequencer is idle
  a_snap_idle: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> (state == ST_IDLE))
    else $error("mesh box arrived while results still pending");

  // index never runs past the last result of the mesh
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (idx <= last_idx))
    else $error("result index past end of mesh");

  // triangle mesh is a single zero result
  a_mesh_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (proxy_kind == KIND_MESH)) |->
      (last_result && (point_x == '0) && (point_y == '0) && (point_z == '0)))
    else $error("triangle mesh result not a single zero item");

  // radius only carried by capsule results
  a_rad_caps: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (proxy_kind != KIND_CAPS)) |-> (radius == '0))
    else $error("radius set on non-capsule result");

endmodule

FILE: rtl/aabb_collision_proxy_fit_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_proxy_fit_top: bounding box collision proxy fitter
// Vertex stream in, mesh, capsule or box proxy results out.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle unless stalled, each folded into six
// running extremes and a saturating count by a min and a max compare per
// axis. Only the vertex marked last produces results: its extremes are
// latched, the emitter registers extents and centres, then the proxy
// decision, and the proxy results leave through the output register at one
// per transfer (one for a triangle mesh, two for a capsule, eight box
// corners). Vertices of the next mesh keep flowing while those results
// drain; only a further last vertex is stalled until the previous mesh's
// final result sits in the output register.
// ----------------------------------------------------------------------------
module aabb_collision_proxy_fit_top (
  input  logic                clk,
  input  logic                rst,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  // vertex channel
  input  logic                vertex_valid,
  output logic                vertex_stall,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic                mesh_static,
  input  logic                last_vertex,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          proxy_kind,
  output logic signed [31:0]  point_x,
  output logic signed [31:0]  point_y,
  output logic signed [31:0]  point_z,
  output logic [30:0]         radius,
  output logic                last_result
);
  import aabb_pkg::*;

  logic [LimitW-1:0] trimesh_vertex_limit;
  logic              busy;
  logic              snap_valid;
  aabb_box_t         snap;

  // triangle mesh vertex limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trimesh_vertex_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      trimesh_vertex_limit <= cfg_data;
    end
  end

  aabb_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .mesh_static  (mesh_static),
    .last_vertex  (last_vertex),
    .limit        (trimesh_vertex_limit),
    .busy         (busy),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  aabb_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .proxy_kind   (proxy_kind),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .radius       (radius),
    .last_result  (last_result)
  );

endmodule

FILE: sim/aabb_proxy_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_proxy_checker: scoreboard for the bounding box collision proxy fitter
// Watches the configuration, vertex and result transfers. Keeps its own copy
// of the per-axis extremes, vertex count and mesh limit, predicts the proxy
// results of every mesh, and compares each accepted result against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module aabb_proxy_checker
  import aabb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  // vertex channel
  input  logic               vertex_valid,
  input  logic               vertex_stall,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               mesh_static,
  input  logic               last_vertex,
  // result channel
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         proxy_kind,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [30:0]        radius,
  input  logic               last_result,
  // status toward the testbench top
  output int                 mismatch_count,
  output int                 results_pending,
  output int                 mesh_seen,
  output int                 caps_seen,
  output int                 box_seen
);

  // one predicted proxy result
  typedef struct {
    proxy_kind_t        kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        rad;
    logic               fin;
  } proxy_result_t;

  proxy_result_t expected_proxies[$];

  // shadow state of the fitter
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [CountW-1:0]  vert_count;
  logic [LimitW-1:0]  mesh_limit;

  function automatic proxy_result_t make_proxy(input proxy_kind_t kind,
                                               input longint x, y, z, r,
                                               input logic fin);
    proxy_result_t p;
    p.kind = kind;
    p.px   = x[31:0];
    p.py   = y[31:0];
    p.pz   = z[31:0];
    p.rad  = r[30:0];
    p.fin  = fin;
    return p;
  endfunction

  task automatic clear_extremes();
    lo_x = COORD_POS_MAX;
    hi_x = COORD_NEG_MAX;
    lo_y = COORD_POS_MAX;
    hi_y = COORD_NEG_MAX;
    lo_z = COORD_POS_MAX;
    hi_z = COORD_NEG_MAX;
    vert_count = '0;
  endtask

  // fold one vertex in; on the last vertex predict the proxy and restart
  task automatic fold_vertex(input logic signed [31:0] x, y, z,
                             input logic is_static, input logic fin);
    longint height, wide_x, wide_z, wide_max, rad, sum_x, sum_z;
    longint px, py, pz;
    int     k;
    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;
    if (z < lo_z) lo_z = z;
    if (z > hi_z) hi_z = z;
    if (vert_count != COUNT_MAX) vert_count++;
    if (fin) begin
      height   = longint'(hi_y) - longint'(lo_y);
      wide_x   = longint'(hi_x) - longint'(lo_x);
      wide_z   = longint'(hi_z) - longint'(lo_z);
      wide_max = (wide_x > wide_z) ? wide_x : wide_z;
      if (is_static || vert_count > mesh_limit) begin
        expected_proxies.push_back(make_proxy(KIND_MESH, 0, 0, 0, 0, 1'b1));
      end else if (wide_max > 0 && height > 3 * wide_max) begin
        // capsule: center rounds toward minus infinity
        rad   = wide_max / 2;
        sum_x = longint'(lo_x) + longint'(hi_x);
        sum_z = longint'(lo_z) + longint'(hi_z);
        expected_proxies.push_back(make_proxy(KIND_CAPS, sum_x >>> 1,
                                              longint'(lo_y) + rad, sum_z >>> 1,
                                              rad, 1'b0));
        expected_proxies.push_back(make_proxy(KIND_CAPS, sum_x >>> 1,
                                              longint'(hi_y) - rad, sum_z >>> 1,
                                              rad, 1'b1));
      end else begin
        // box corners, x fastest then y then z
        for (k = 0; k < 8; k++) begin
          px = k[0] ? hi_x : lo_x;
          py = k[1] ? hi_y : lo_y;
          pz = k[2] ? hi_z : lo_z;
          expected_proxies.push_back(make_proxy(KIND_BOX, px, py, pz, 0, k == 7));
        end
      end
      clear_extremes();
    end
  endtask

  function automatic void field_check(input string name,
                                      input logic signed [63:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    proxy_result_t want;
    if (expected_proxies.size() == 0) begin
      $display("%0t: result with nothing expected, kind %0d point (%0d, %0d, %0d)",
               $time, proxy_kind, point_x, point_y, point_z);
      mismatch_count++;
    end else begin
      want = expected_proxies.pop_front();
      field_check("proxy_kind", want.kind, proxy_kind);
      field_check("point_x", want.px, point_x);
      field_check("point_y", want.py, point_y);
      field_check("point_z", want.pz, point_z);
      field_check("radius", want.rad, radius);
      field_check("last_result", want.fin, last_result);
      case (want.kind)
        KIND_MESH: mesh_seen++;
        KIND_CAPS: caps_seen++;
        default:   box_seen++;
      endcase
    end
  endtask

  // sample every transfer at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_extremes();
      mesh_limit = LIMIT_RESET;
      expected_proxies.delete();
      mismatch_count = 0;
      mesh_seen = 0;
      caps_seen = 0;
      box_seen = 0;
    end else begin
      if (result_valid && !result_stall) check_result();
      if (vertex_valid && !vertex_stall)
        fold_vertex(coord_x, coord_y, coord_z, mesh_static, last_vertex);
      if (cfg_valid && cfg_ready) mesh_limit = cfg_data;
    end
    results_pending = expected_proxies.size();
  end

endmodule

FILE: sim/tb_aabb_collision_proxy_fit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_collision_proxy_fit_top: testbench of the collision proxy fitter
// Drives directed and random meshes through the vertex channel, rewrites the
// vertex limit between meshes, stalls the result side at random, and leaves
// prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_aabb_collision_proxy_fit_top;
  import aabb_pkg::*;

  localparam int LONG_HOLD         = 300;
  localparam int IDLE_LIMIT        = 4000;
  localparam int SETTLE_CYCLES     = 16;
  localparam int DRAIN_CYCLES      = 24;
  localparam int PHASE_VERTICES    = 20;
  localparam int RANDOM_PHASES     = 6;

  // coordinate flavors for random meshes
  localparam int COORD_FULL    = 0;
  localparam int COORD_SMALL   = 1;
  localparam int COORD_EXTREME = 2;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;
  logic               vertex_valid;
  logic               vertex_stall;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic               mesh_static;
  logic               last_vertex;
  logic               result_valid;
  logic               result_stall;
  logic [1:0]         proxy_kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [30:0]        radius;
  logic               last_result;

  int mismatch_count;
  int results_pending;
  int mesh_seen;
  int caps_seen;
  int box_seen;
  int vertices_sent;
  int meshes_sent;
  int idle_cycles;
  bit quiet;
  bit long_hold_req;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aabb_collision_proxy_fit_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .mesh_static  (mesh_static),
    .last_vertex  (last_vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .proxy_kind   (proxy_kind),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .radius       (radius),
    .last_result  (last_result)
  );

  aabb_proxy_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .vertex_valid    (vertex_valid),
    .vertex_stall    (vertex_stall),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .coord_z         (coord_z),
    .mesh_static     (mesh_static),
    .last_vertex     (last_vertex),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .proxy_kind      (proxy_kind),
    .point_x         (point_x),
    .point_y         (point_y),
    .point_z         (point_z),
    .radius          (radius),
    .last_result     (last_result),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .mesh_seen       (mesh_seen),
    .caps_seen       (caps_seen),
    .box_seen        (box_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic signed [31:0] pick_coord(input int flavor);
    case (flavor)
      COORD_FULL:  return $urandom;
      COORD_SMALL: return $urandom_range(0, 2097152) - 1048576;
      default: begin
        case ($urandom_range(0, 4))
          0:       return COORD_NEG_MAX;
          1:       return COORD_POS_MAX;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(2, 8));
      3:       return LIMIT_RESET;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one vertex, hold it until the transfer, then maybe idle
  task automatic push_vertex(input logic signed [31:0] x, y, z,
                             input logic is_static, input logic fin);
    int gap;
    vertex_valid = 1'b1;
    coord_x      = x;
    coord_y      = y;
    coord_z      = z;
    mesh_static  = is_static;
    last_vertex  = fin;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
    vertices_sent++;
    if (fin) meshes_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      vertex_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // quiet the vertex side and let every predicted result drain
  task automatic wait_idle();
    vertex_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_mesh();
    int                 n, shape, spread, tall, i;
    logic signed [31:0] bx, by, bz, y;
    logic               st, fin;
    n      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    shape  = $urandom_range(0, 9);
    spread = $urandom_range(1, 4000);
    tall   = spread * $urandom_range(2, 40);
    bx     = pick_coord(COORD_SMALL);
    by     = pick_coord(COORD_SMALL);
    bz     = pick_coord(COORD_SMALL);
    for (i = 0; i < n; i++) begin
      fin = (i == n - 1);
      st  = fin ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
      if (shape < 4) begin
        // narrow column, tall enough for a capsule most of the time
        if (i == 0) y = by;
        else if (fin) y = by + tall;
        else y = by + $urandom_range(0, tall);
        push_vertex(bx + $urandom_range(0, spread), y, bz + $urandom_range(0, spread),
                    st, fin);
      end else if (shape < 8) begin
        push_vertex(pick_coord(COORD_SMALL), pick_coord(COORD_SMALL),
                    pick_coord(COORD_SMALL), st, fin);
      end else if (shape == 8) begin
        push_vertex(pick_coord(COORD_FULL), pick_coord(COORD_FULL),
                    pick_coord(COORD_FULL), st, fin);
      end else begin
        push_vertex(pick_coord(COORD_EXTREME), pick_coord(COORD_EXTREME),
                    pick_coord(COORD_EXTREME), st, fin);
      end
    end
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_side
    int run;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        result_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        result_stall  = 1'b0;
      end else begin
        run = pick_gap();
        if (run > 0) begin
          result_stall = 1'b1;
          repeat (run) @(negedge clk);
          result_stall = 1'b0;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (vertex_valid && !vertex_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL aabb_collision_proxy_fit_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int phase, target, i;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    vertex_valid  = 1'b0;
    coord_x       = '0;
    coord_y       = '0;
    coord_z       = '0;
    mesh_static   = 1'b0;
    last_vertex   = 1'b0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    vertices_sent = 0;
    meshes_sent   = 0;
    idle_cycles   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single vertex: flat box at the origin, limit still at reset value
    push_vertex(0, 0, 0, 1'b0, 1'b1);
    // static flag on a non-last vertex is ignored
    push_vertex(5, 5, 5, 1'b1, 1'b0);
    push_vertex(7, -7, 7, 1'b0, 1'b1);
    // static flag on the last vertex forces a triangle mesh
    push_vertex(1, 2, 3, 1'b0, 1'b0);
    push_vertex(4, 5, 6, 1'b1, 1'b1);
    // capsule with odd negative center sums
    push_vertex(-3, 0, -1, 1'b0, 1'b0);
    push_vertex(0, 100, 0, 1'b0, 1'b1);
    // height exactly three times the width stays a box
    push_vertex(0, 0, 0, 1'b0, 1'b0);
    push_vertex(2, 6, 1, 1'b0, 1'b1);
    // full-range extents on every axis
    push_vertex(COORD_NEG_MAX, COORD_NEG_MAX, COORD_NEG_MAX, 1'b0, 1'b0);
    push_vertex(COORD_POS_MAX, COORD_POS_MAX, COORD_POS_MAX, 1'b0, 1'b1);
    // full-range height with unit width: capsule of zero radius
    push_vertex(0, COORD_NEG_MAX, 0, 1'b0, 1'b0);
    push_vertex(1, COORD_POS_MAX, -1, 1'b0, 1'b1);
    // z is the wider horizontal extent
    push_vertex(0, 0, 0, 1'b0, 1'b0);
    push_vertex(1, 1000, 10, 1'b0, 1'b1);
    // tall but zero horizontal extent gives a box
    push_vertex(0, 0, 0, 1'b0, 1'b0);
    push_vertex(0, 1000, 0, 1'b0, 1'b1);

    // count equal to the limit passes, one more falls back to a mesh
    write_limit(16'd3);
    for (i = 0; i < 3; i++) push_vertex(i, 2 * i, -i, 1'b0, i == 2);
    for (i = 0; i < 4; i++) push_vertex(-i, i, 3 * i, 1'b0, i == 3);
    write_limit(16'd0);
    push_vertex(9, 9, 9, 1'b0, 1'b1);

    // random phases, each under its own limit
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_limit(pick_limit());
      quiet = (phase == 1);
      if (phase == 2) long_hold_req = 1'b1;
      target = vertices_sent + PHASE_VERTICES;
      while (vertices_sent < target) begin
        random_mesh();
        // sender pause until the block has drained
        if (phase == 3) begin
          vertex_valid = 1'b0;
          while (results_pending != 0) @(negedge clk);
        end
      end
    end
    quiet = 1'b0;

    // drain and verdict
    vertex_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d vertices in %0d meshes under %0d limit settings",
             vertices_sent, meshes_sent, RANDOM_PHASES + 3);
    $display("Checked %0d triangle mesh, %0d capsule and %0d box results",
             mesh_seen, caps_seen, box_seen);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS aabb_collision_proxy_fit_top");
    end else begin
      $display("FAIL aabb_collision_proxy_fit_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/aabb_pkg.sv
rtl/aabb_accum.sv
rtl/aabb_emit.sv
rtl/aabb_collision_proxy_fit_top.sv
sim/aabb_proxy_checker.sv
sim/tb_aabb_collision_proxy_fit_top.sv
